>>> rtl/pctd_pkg.sv
`default_nettype none

package pctd_pkg;

  localparam int unsigned SYM_W = 8;
  localparam logic [SYM_W-1:0] BLANK_SYMBOL = 8'h20;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DECODE = 2'd1,
    CMD_END    = 2'd2
  } command_t;

  typedef enum logic [2:0] {
    ST_SYMBOL      = 3'd0,
    ST_SYMBOL_DROP = 3'd1,
    ST_DROP        = 3'd2,
    ST_STORED      = 3'd3,
    ST_FULL        = 3'd4
  } status_t;

endpackage

`default_nettype wire

>>> rtl/pctd_node_ram.sv
`default_nettype none

module pctd_node_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 28
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/prefix_code_trie_decoder.sv
// Prefix code tree decoder. A binary code tree is kept in a node table and
// a coded bit stream is decoded by walking it.
// Input channel (in_valid / in_stall): a transfer carries a command. Add
// stores code_symbol at the end of the code_length bits of code_bits, first
// bit at position code_length minus one. Decode moves one message_bit along
// the tree. End emits the current node's symbol with last_symbol set and
// returns to the root.
// Output channel (out_valid / out_stall): one result transfer per add, per
// end, and per decode bit that leaves a node without a child for it.
// Table access: a node visit is a read of the node table, a synchronous RAM
// with separate read and write ports; a node just allocated by an add is
// built locally instead. A decode reads its node, and the root as well when
// it falls back there. An end reads its node. An add makes one access per
// level of the code length, capped at MAX_CODE_BITS, plus a symbol write,
// fewer on a full table. A finished result sits in an output register, so
// the next transfer can be accepted while out_stall holds the previous result.
// A result that is ready while the output register is still stalled waits in its final step.
// Reset: after rst falls, the block spends one cycle writing the root entry
// (blank symbol, no children) and then accepts input. Other table entries are
// written when they are allocated, so nodes_used bounds every valid entry.
`default_nettype none

module prefix_code_trie_decoder #(
  parameter int unsigned MAX_NODES     = 512,
  parameter int unsigned MAX_CODE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [15:0] code_bits,
  input  wire logic [4:0]  code_length,
  input  wire logic [7:0]  code_symbol,
  input  wire logic        message_bit,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       symbol,
  output logic [2:0]       status,
  output logic             last_symbol
);

  import pctd_pkg::*;

  localparam int unsigned NODE_W = $clog2(MAX_NODES);
  localparam int unsigned USED_W = $clog2(MAX_NODES + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_CODE_BITS + 1);

  // One table entry: both child links, their present bits and the symbol.
  typedef struct packed {
    logic [NODE_W-1:0] child1;
    logic [NODE_W-1:0] child0;
    logic [1:0]        present;
    logic [SYM_W-1:0]  sym;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_ADD  = 6'b000100,
    S_DEC  = 6'b001000,
    S_ROOT = 6'b010000,
    S_END  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [USED_W-1:0] nodes_used, nodes_used_next;
  logic [NODE_W-1:0] current_node, current_node_next;

  // Working registers of the add walk and the decode step.
  logic [NODE_W-1:0] node, node_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [15:0]       code_r;
  logic [SYM_W-1:0]  sym_r;
  logic              bit_r;
  logic              use_rd, use_rd_next;
  entry_t            cur_e, cur_e_next;
  logic [SYM_W-1:0]  emitted, emitted_next;

  // Table port.
  logic              rd_en;
  logic [NODE_W-1:0] rd_addr;
  logic [ENTRY_W-1:0] rd_q;
  entry_t            rd_e;
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  entry_t            wr_data;

  // Result to load into the output register.
  logic              emit;
  logic [SYM_W-1:0]  emit_sym;
  status_t           emit_status;
  logic              emit_last;

  logic              accept;
  logic              out_free;
  entry_t            blank_e;
  entry_t            walk_e;
  entry_t            link_e;
  logic [CNT_W+3:0]  pos;
  logic              walk_bit;
  logic [NODE_W-1:0] walk_child;
  logic [NODE_W-1:0] fresh;
  logic [CNT_W-1:0]  clamped_len;

  pctd_node_ram #(
    .DEPTH (MAX_NODES),
    .WIDTH (ENTRY_W)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  assign rd_e     = rd_q;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    blank_e         = '0;
    blank_e.child1  = '0;
    blank_e.child0  = '0;
    blank_e.present = 2'b00;
    blank_e.sym     = BLANK_SYMBOL;
  end

  assign clamped_len = ({1'b0, code_length} > 6'(MAX_CODE_BITS)) ?
                       CNT_W'(MAX_CODE_BITS) : CNT_W'(code_length);

  // The entry of the node being walked: fresh from the table after a read,
  // or the locally built blank entry of a node just allocated.
  assign walk_e     = use_rd ? rd_e : cur_e;
  assign pos        = {4'b0000, cnt} - (CNT_W + 4)'(1);
  assign walk_bit   = (pos < (CNT_W + 4)'(16)) ? code_r[pos[3:0]] : 1'b0;
  assign walk_child = walk_bit ? walk_e.child1 : walk_e.child0;
  assign fresh      = nodes_used[NODE_W-1:0];

  always_comb begin
    link_e = walk_e;
    if (walk_bit) begin
      link_e.child1     = fresh;
      link_e.present[1] = 1'b1;
    end else begin
      link_e.child0     = fresh;
      link_e.present[0] = 1'b1;
    end
  end

  always_comb begin
    state_next        = state;
    nodes_used_next   = nodes_used;
    current_node_next = current_node;
    node_next         = node;
    cnt_next          = cnt;
    use_rd_next       = use_rd;
    cur_e_next        = cur_e;
    emitted_next      = emitted;
    rd_en             = 1'b0;
    rd_addr           = current_node;
    wr_en             = 1'b0;
    wr_addr           = node;
    wr_data           = walk_e;
    emit              = 1'b0;
    emit_sym          = '0;
    emit_status       = ST_SYMBOL;
    emit_last         = 1'b0;

    unique case (state)
      S_INIT: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = blank_e;
        state_next = S_IDLE;
      end

      S_IDLE: begin
        if (accept) begin
          unique case (command)
            CMD_ADD: begin
              rd_en       = 1'b1;
              rd_addr     = '0;
              node_next   = '0;
              cnt_next    = clamped_len;
              use_rd_next = 1'b1;
              state_next  = S_ADD;
            end
            CMD_DECODE: begin
              rd_en      = 1'b1;
              state_next = S_DEC;
            end
            CMD_END: begin
              rd_en      = 1'b1;
              state_next = S_END;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_ADD: begin
        priority if (cnt == '0) begin
          // End of the code: put the symbol on the node reached.
          if (out_free) begin
            wr_en       = 1'b1;
            wr_data     = walk_e;
            wr_data.sym = sym_r;
            emit        = 1'b1;
            emit_status = ST_STORED;
            state_next  = S_IDLE;
          end
        end else if (walk_e.present[walk_bit]) begin
          rd_en       = 1'b1;
          rd_addr     = walk_child;
          node_next   = walk_child;
          use_rd_next = 1'b1;
          cnt_next    = cnt - CNT_W'(1);
        end else if (nodes_used >= USED_W'(MAX_NODES)) begin
          // Table full: the node reached is written as it stands, so a node
          // allocated in an earlier step is never left unwritten.
          if (out_free) begin
            wr_en       = 1'b1;
            wr_data     = walk_e;
            emit        = 1'b1;
            emit_status = ST_FULL;
            state_next  = S_IDLE;
          end
        end else begin
          wr_en           = 1'b1;
          wr_data         = link_e;
          node_next       = fresh;
          cur_e_next      = blank_e;
          use_rd_next     = 1'b0;
          nodes_used_next = nodes_used + USED_W'(1);
          cnt_next        = cnt - CNT_W'(1);
        end
      end

      S_DEC: begin
        priority if (rd_e.present[bit_r]) begin
          current_node_next = bit_r ? rd_e.child1 : rd_e.child0;
          state_next        = S_IDLE;
        end else if (current_node == '0) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = ST_DROP;
            state_next  = S_IDLE;
          end
        end else begin
          // No child here: keep the symbol and retry the bit at the root.
          emitted_next = rd_e.sym;
          rd_en        = 1'b1;
          rd_addr      = '0;
          state_next   = S_ROOT;
        end
      end

      S_ROOT: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_sym   = emitted;
          state_next = S_IDLE;
          if (rd_e.present[bit_r]) begin
            current_node_next = bit_r ? rd_e.child1 : rd_e.child0;
            emit_status       = ST_SYMBOL;
          end else begin
            current_node_next = '0;
            emit_status       = ST_SYMBOL_DROP;
          end
        end
      end

      S_END: begin
        if (out_free) begin
          emit              = 1'b1;
          emit_sym          = rd_e.sym;
          emit_status       = ST_SYMBOL;
          emit_last         = 1'b1;
          current_node_next = '0;
          state_next        = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      nodes_used   <= USED_W'(1);
      current_node <= '0;
      out_valid    <= 1'b0;
      use_rd       <= 1'b0;
    end else begin
      state        <= state_next;
      nodes_used   <= nodes_used_next;
      current_node <= current_node_next;
      use_rd       <= use_rd_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    node    <= node_next;
    cnt     <= cnt_next;
    cur_e   <= cur_e_next;
    emitted <= emitted_next;
    if (accept) begin
      code_r <= code_bits;
      sym_r  <= code_symbol;
      bit_r  <= message_bit;
    end
    if (emit) begin
      symbol      <= emit_sym;
      status      <= emit_status;
      last_symbol <= emit_last;
    end
  end

  // The node count always covers the root and never passes the table size.
  a_nodes_used_range: assert property (@(posedge clk) disable iff (rst)
    (nodes_used >= USED_W'(1)) && (nodes_used <= USED_W'(MAX_NODES)))
    else $error("nodes_used out of range");

  // The decode position always points at an allocated node.
  a_current_allocated: assert property (@(posedge clk) disable iff (rst)
    state != S_INIT |-> {{(USED_W - NODE_W){1'b0}}, current_node} < nodes_used)
    else $error("current_node beyond allocated nodes");

  // A new result is never loaded over one that the receiver still stalls.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(emit && out_valid && out_stall))
    else $error("result overwrites a stalled output");

  // A decode transfer always enters the node read state S_DEC in the next cycle.
  a_decode_reads: assert property (@(posedge clk) disable iff (rst)
    accept && (command == CMD_DECODE) |=> state == S_DEC)
    else $error("decode transfer did not enter the node read");

endmodule

`default_nettype wire

>>> bench/tb_prefix_code_trie_decoder.sv
`timescale 1ns / 1ps

// Self-checking bench for the prefix code tree decoder.
//
// An initial block queues every command up front. A directed opening walks
// the corner cases, then random traffic follows in two parts. The first part
// builds a small codebook and decodes messages made of its codewords. The
// second part floods the node table with long codes until it overflows, then
// decodes again on the crowded tree.
//
// A clocked driver offers the queued commands. Each accepted transfer updates
// a private copy of the code tree, and any response that the command should
// produce goes into a queue. A clocked monitor pops that queue on every
// accepted response and compares the fields. Both sides idle in short random
// bursts, the receiver holds off once for a long stretch to back the block
// up, and the tail of the run is free of idling.
module tb_prefix_code_trie_decoder;
  import pctd_pkg::*;

  localparam int TRIE_NODES = 512;
  localparam int MAX_CODE_LEN = 16;
  // The command port has one code that the block ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int ITEM_TARGET = 1550;
  localparam int BOOK_SIZE = 24;
  localparam int FILL_ADDS = 50;
  localparam int QUIET_ITEMS = 200;
  localparam int HOLD_AT = 600;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] bits;
    logic [4:0]  len;
    logic [7:0]  sym;
    logic        mbit;
  } trie_cmd_t;

  typedef struct {
    logic [7:0] sym;
    status_t    st;
    logic       last;
  } trie_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = CMD_ADD;
  logic [15:0] code_bits = '0;
  logic [4:0]  code_length = '0;
  logic [7:0]  code_symbol = '0;
  logic        message_bit = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  symbol;
  logic [2:0]  status;
  logic        last_symbol;

  prefix_code_trie_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .code_bits   (code_bits),
    .code_length (code_length),
    .code_symbol (code_symbol),
    .message_bit (message_bit),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol      (symbol),
    .status      (status),
    .last_symbol (last_symbol)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Commands waiting to be offered, and the responses still owed by the block.
  trie_cmd_t cmd_backlog[$];
  trie_out_t symbols_due[$];

  // Codewords that the random messages are assembled from.
  logic [15:0] book_bits[$];
  int          book_len[$];

  // Private copy of the code tree.
  logic [8:0] trie_kid [TRIE_NODES][2];
  logic [1:0] trie_has [TRIE_NODES];
  logic [7:0] trie_sym [TRIE_NODES];
  int unsigned trie_used;
  logic [8:0] trie_cur;

  int total_items = 0;
  int sent_count = 0;
  int fault_count = 0;
  logic quiet_tail;

  assign quiet_tail = (sent_count + QUIET_ITEMS >= total_items);

  task automatic report_fault(input string what);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
  endtask

  // Applies one accepted command to the tree copy and records the response,
  // if the command produces one.
  function automatic void walk_trie(input trie_cmd_t c);
    int unsigned depth;
    int unsigned fresh;
    int i;
    logic [8:0] node;
    logic b;
    bit full;
    trie_out_t r;
    node = '0;
    full = 1'b0;
    r.sym = '0;
    r.st = ST_STORED;
    r.last = 1'b0;
    case (c.cmd)
      CMD_ADD: begin
        // Codes longer than the maximum are cut to it; the first code bit
        // sits at the top of the length.
        depth = (c.len > MAX_CODE_LEN) ? MAX_CODE_LEN : c.len;
        for (i = depth; i > 0 && !full; i--) begin
          b = c.bits[i-1];
          if (trie_has[node][b]) begin
            node = trie_kid[node][b];
          end else if (trie_used >= TRIE_NODES) begin
            // Out of nodes: the partial path stays and the symbol is lost.
            full = 1'b1;
          end else begin
            fresh = trie_used;
            trie_used++;
            trie_has[fresh] = 2'b00;
            trie_sym[fresh] = BLANK_SYMBOL;
            trie_kid[node][b] = fresh[8:0];
            trie_has[node][b] = 1'b1;
            node = fresh[8:0];
          end
        end
        if (full) begin
          r.st = ST_FULL;
        end else begin
          trie_sym[node] = c.sym;
          r.st = ST_STORED;
        end
        symbols_due.insert(symbols_due.size(), r);
      end
      CMD_DECODE: begin
        b = c.mbit;
        if (trie_has[trie_cur][b]) begin
          // Still inside a codeword: no response.
          trie_cur = trie_kid[trie_cur][b];
        end else if (trie_cur == '0) begin
          r.st = ST_DROP;
          symbols_due.insert(symbols_due.size(), r);
        end else begin
          // No child for the bit: emit the node's symbol and retry the bit from the root.
          r.sym = trie_sym[trie_cur];
          if (trie_has[0][b]) begin
            trie_cur = trie_kid[0][b];
            r.st = ST_SYMBOL;
          end else begin
            trie_cur = '0;
            r.st = ST_SYMBOL_DROP;
          end
          symbols_due.insert(symbols_due.size(), r);
        end
      end
      CMD_END: begin
        r.sym = trie_sym[trie_cur];
        r.st = ST_SYMBOL;
        r.last = 1'b1;
        trie_cur = '0;
        symbols_due.insert(symbols_due.size(), r);
      end
      default: begin
      end
    endcase
  endfunction

  // Fields that a command does not use still carry random values.
  function automatic trie_cmd_t scrambled(input logic [1:0] cmd);
    trie_cmd_t c;
    c.cmd = cmd;
    c.bits = 16'($urandom_range(0, 65535));
    c.len = 5'($urandom_range(0, 31));
    c.sym = 8'($urandom_range(0, 255));
    c.mbit = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic queue_add(input logic [15:0] bits, input logic [4:0] len,
                           input logic [7:0] sym);
    trie_cmd_t c;
    c = scrambled(CMD_ADD);
    c.bits = bits;
    c.len = len;
    c.sym = sym;
    cmd_backlog.insert(cmd_backlog.size(), c);
  endtask

  task automatic queue_bit(input logic b);
    trie_cmd_t c;
    c = scrambled(CMD_DECODE);
    c.mbit = b;
    cmd_backlog.insert(cmd_backlog.size(), c);
  endtask

  task automatic queue_plain(input logic [1:0] cmd);
    cmd_backlog.insert(cmd_backlog.size(), scrambled(cmd));
  endtask

  // One message: a few codewords sent first bit first, then usually an end
  // of message, sometimes stray bits, an ignored command or another add.
  task automatic queue_message(input int max_len);
    int words;
    int k;
    int j;
    int w;
    logic [15:0] cw;
    words = $urandom_range(1, 8);
    for (k = 0; k < words; k++) begin
      w = $urandom_range(0, book_len.size() - 1);
      cw = book_bits[w];
      for (j = book_len[w] - 1; j >= 0; j--) queue_bit(cw[j]);
    end
    case ($urandom_range(0, 9))
      0: begin
        words = $urandom_range(1, 6);
        for (k = 0; k < words; k++) queue_bit(1'($urandom_range(0, 1)));
      end
      1: begin
        queue_plain(CMD_UNUSED);
      end
      2: begin
        queue_add(16'($urandom_range(0, 65535)), 5'($urandom_range(0, max_len)),
                  8'($urandom_range(0, 255)));
      end
      default: begin
        queue_plain(CMD_END);
      end
    endcase
  endtask

  initial begin
    int k;
    int n;
    logic [15:0] cw;

    for (k = 0; k < TRIE_NODES; k++) begin
      trie_has[k] = 2'b00;
      trie_sym[k] = BLANK_SYMBOL;
    end
    trie_used = 1;
    trie_cur = '0;

    // Empty tree: both bits are dropped at the root, and an end gives the
    // blank root symbol. The ignored command must not produce anything.
    queue_bit(1'b0);
    queue_bit(1'b1);
    queue_plain(CMD_END);
    queue_plain(CMD_UNUSED);
    // An empty code labels the root itself.
    queue_add(16'h0000, 5'd0, 8'hFF);
    queue_plain(CMD_END);
    // Over-long code: cut to sixteen ones.
    queue_add(16'hFFFF, 5'd20, 8'h00);
    // Walk two ones, then a zero that neither the node nor the root knows,
    // so the symbol comes out together with the dropped bit.
    queue_bit(1'b1);
    queue_bit(1'b1);
    queue_bit(1'b0);
    // End while sitting at the root.
    queue_plain(CMD_END);
    queue_add(16'h0000, 5'd16, 8'hA5);
    queue_add(16'h0002, 5'd2, 8'h41);
    queue_add(16'h0001, 5'd1, 8'h42);
    // Start decoding, then add a code in the middle of it; the decode
    // position must not move.
    queue_bit(1'b1);
    queue_add(16'h8001, 5'd31, 8'h7E);
    queue_bit(1'b0);
    // Go one node deeper, then fall off the new code's path and retry at the root.
    queue_bit(1'b0);
    queue_bit(1'b1);
    queue_plain(CMD_END);
    queue_plain(CMD_END);

    // A small codebook with short codes, then messages written in it.
    for (k = 0; k < BOOK_SIZE; k++) begin
      cw = 16'($urandom_range(0, 65535));
      n = $urandom_range(1, 8);
      book_bits.insert(book_bits.size(), cw);
      book_len.insert(book_len.size(), n);
      queue_add(cw, n[4:0], 8'($urandom_range(0, 255)));
    end
    while (cmd_backlog.size() < 1000) queue_message(8);

    // Long random codes until the node table overflows; later adds either
    // land on existing paths or report a full table.
    for (k = 0; k < FILL_ADDS; k++) begin
      queue_add(16'($urandom_range(0, 65535)), 5'd16, 8'($urandom_range(0, 255)));
    end
    while (cmd_backlog.size() < ITEM_TARGET) queue_message(31);
    total_items = cmd_backlog.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Every command has been taken and every response has come back; give
    // the block time to show any stray response before the verdict.
    while (!(sent_count == total_items && symbols_due.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (symbols_due.size() != 0) begin
      report_fault($sformatf("%0d responses never arrived", symbols_due.size()));
    end
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Driver. A new command goes out only when the previous one has been
  // taken or nothing is on offer. Idle gaps come in bursts whose frequency
  // changes every 64 transfers, including stretches without any.
  trie_cmd_t cur_cmd;
  int gap_left = 0;
  int gap_odds = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      gap_odds <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        walk_trie(cur_cmd);
        sent_count <= sent_count + 1;
        if (sent_count % 64 == 63) gap_odds <= $urandom_range(0, 5);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (!quiet_tail && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
          gap_left <= $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          cur_cmd = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          command <= cur_cmd.cmd;
          code_bits <= cur_cmd.bits;
          code_length <= cur_cmd.len;
          code_symbol <= cur_cmd.sym;
          message_bit <= cur_cmd.mbit;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Short random stall bursts, plus one long hold-off once enough
  // commands have gone in, so the output register and the block's final
  // step both fill and the input side has to stall.
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && sent_count >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor. Responses must come back in command order.
  trie_out_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (symbols_due.size() == 0) begin
        report_fault($sformatf("unexpected response: symbol %02h status %0d last %0d",
                               symbol, status, last_symbol));
      end else begin
        want = symbols_due.pop_front();
        if (symbol !== want.sym || status !== want.st || last_symbol !== want.last) begin
          report_fault($sformatf({"mismatch: expected symbol %02h status %0d last %0d,",
                                  " got symbol %02h status %0d last %0d"},
                                 want.sym, want.st, want.last,
                                 symbol, status, last_symbol));
        end
      end
    end
  end

endmodule

>>> prefix_code_trie_decoder.f
rtl/pctd_pkg.sv
rtl/pctd_node_ram.sv
rtl/prefix_code_trie_decoder.sv
bench/tb_prefix_code_trie_decoder.sv
